// ===== design/websocket_frame_deframer_core_macros.svh =====
// Assertion macros shared by the frame deframer RTL.
// Used by files that carry concurrent checks; needs no other file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define WSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/wsd_pkg.sv =====
// Shared types, codes and helpers for the frame deframer.
// Used by wsd_parser and websocket_frame_deframer_core; depends on nothing.
`default_nettype none

package wsd_pkg;

  localparam int TOTAL_COUNT_BITS_DEF = 32;

  localparam logic [31:0] MAX_LEN_RESET = 32'd16777216;

  // Configuration register indexes.
  localparam logic CFG_IDX_MAX_LEN = 1'b0;
  localparam logic CFG_IDX_CLOSING = 1'b1;

  // Frame opcodes.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Payload kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // Events.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_MSG_DONE = 3'd1;
  localparam logic [2:0] EV_PING     = 3'd2;
  localparam logic [2:0] EV_CLOSE    = 3'd3;
  localparam logic [2:0] EV_ERROR    = 3'd4;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_RSV       = 3'd1;
  localparam logic [2:0] ERR_STRAY     = 3'd2;
  localparam logic [2:0] ERR_MID_MSG   = 3'd3;
  localparam logic [2:0] ERR_BAD_OP    = 3'd4;
  localparam logic [2:0] ERR_CLOSING   = 3'd5;
  localparam logic [2:0] ERR_BAD_CTRL  = 3'd6;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd7;

  // Length field codes.
  localparam logic [6:0] CTRL_MAX_LEN = 7'd125;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  payload_byte;
    logic [1:0]  byte_kind;
    logic [3:0]  message_opcode;
    logic [2:0]  event_res;
    logic        last_flag;
    logic [2:0]  error_code;
    logic [31:0] payload_total;
  } res_t;

  function automatic logic is_ctrl(input logic [3:0] op);
    return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

  function automatic logic is_data(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN);
  endfunction

  function automatic logic [1:0] kind_of(input logic [3:0] op);
    logic [1:0] k;
    k = KIND_DATA;
    if (op == OP_PING) k = KIND_PING;
    else if (op == OP_CLOSE) k = KIND_CLOSE;
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== design/wsd_parser.sv =====
// Frame parser state and the per-byte next-state and result logic.
// Depends on wsd_pkg and websocket_frame_deframer_core_macros.svh.
`default_nettype none
`include "websocket_frame_deframer_core_macros.svh"

module wsd_parser #(
  parameter int TOTAL_COUNT_BITS = wsd_pkg::TOTAL_COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [31:0]   max_len,
  input  wire logic          closing,
  output logic               emit,
  output wsd_pkg::res_t      res
);

  localparam int SAT_W = (TOTAL_COUNT_BITS < 32) ? TOTAL_COUNT_BITS : 32;

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        act_r, act_nxt;
  logic [3:0]  mtype_r, mtype_nxt;
  logic        mask_en_r, mask_en_nxt;
  logic [31:0] key_r, key_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [1:0]  pidx_r, pidx_nxt;
  logic [63:0] mtot_r, mtot_nxt;
  logic [6:0]  ctot_r, ctot_nxt;

  function automatic logic [31:0] sat_total(input logic [63:0] v);
    logic [31:0] r;
    r = '0;
    if (|v[63:SAT_W]) r[SAT_W-1:0] = '1;
    else r[SAT_W-1:0] = v[SAT_W-1:0];
    return r;
  endfunction

  always_comb begin
    logic        len_go;
    logic [63:0] len_val;
    logic        start_go;
    logic [63:0] start_len;
    logic        fe_go;
    logic        fe_has;
    logic [7:0]  fe_data;
    logic [2:0]  err;
    logic [6:0]  len7;
    logic [63:0] rem_dec;
    logic [63:0] room;
    logic [7:0]  data;

    phase_nxt   = phase_r;
    fin_nxt     = fin_r;
    op_nxt      = op_r;
    act_nxt     = act_r;
    mtype_nxt   = mtype_r;
    mask_en_nxt = mask_en_r;
    key_nxt     = key_r;
    hcnt_nxt    = hcnt_r;
    rem_nxt     = rem_r;
    pidx_nxt    = pidx_r;
    mtot_nxt    = mtot_r;
    ctot_nxt    = ctot_r;
    emit        = 1'b0;
    res         = '0;
    len_go      = 1'b0;
    len_val     = '0;
    start_go    = 1'b0;
    start_len   = '0;
    fe_go       = 1'b0;
    fe_has      = 1'b0;
    fe_data     = '0;
    err         = wsd_pkg::ERR_NONE;
    len7        = rx_byte[6:0];
    rem_dec     = rem_r - 64'd1;
    room        = {32'd0, max_len} - mtot_r;
    data        = rx_byte ^ (mask_en_r ? key_r[{~pidx_r, 3'b000} +: 8] : 8'h00);

    if (step) begin
      case (phase_r)
        wsd_pkg::PH_HDR0: begin
          op_nxt  = rx_byte[3:0];
          fin_nxt = rx_byte[7];
          if (rx_byte[6:4] != 3'b000) begin
            err = wsd_pkg::ERR_RSV;
          end else if (!act_r && op_nxt == wsd_pkg::OP_CONT) begin
            err = wsd_pkg::ERR_STRAY;
          end else if (act_r && !wsd_pkg::is_ctrl(op_nxt) && op_nxt != wsd_pkg::OP_CONT) begin
            err = wsd_pkg::ERR_MID_MSG;
          end else if (!(wsd_pkg::is_data(op_nxt) || wsd_pkg::is_ctrl(op_nxt))) begin
            err = wsd_pkg::ERR_BAD_OP;
          end else if (closing && op_nxt != wsd_pkg::OP_CLOSE) begin
            err = wsd_pkg::ERR_CLOSING;
          end else begin
            if (op_nxt == wsd_pkg::OP_TEXT || op_nxt == wsd_pkg::OP_BIN) begin
              act_nxt   = 1'b1;
              mtype_nxt = op_nxt;
              mtot_nxt  = '0;
            end
            phase_nxt = wsd_pkg::PH_HDR1;
          end
        end
        wsd_pkg::PH_HDR1: begin
          mask_en_nxt = rx_byte[7];
          if (wsd_pkg::is_ctrl(op_r) && (!fin_r || len7 > wsd_pkg::CTRL_MAX_LEN)) begin
            err = wsd_pkg::ERR_BAD_CTRL;
          end else begin
            rem_nxt = '0;
            if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
              hcnt_nxt  = (len7 == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                       : wsd_pkg::EXT64_BYTES;
              phase_nxt = wsd_pkg::PH_EXTLEN;
            end else begin
              len_go  = 1'b1;
              len_val = {57'd0, len7};
            end
          end
        end
        wsd_pkg::PH_EXTLEN: begin
          rem_nxt  = {rem_r[55:0], rx_byte};
          hcnt_nxt = hcnt_r - 4'd1;
          if (hcnt_r == 4'd1) begin
            len_go  = 1'b1;
            len_val = {rem_r[55:0], rx_byte};
          end
        end
        wsd_pkg::PH_MASK: begin
          key_nxt  = {key_r[23:0], rx_byte};
          hcnt_nxt = hcnt_r - 4'd1;
          if (hcnt_r == 4'd1) begin
            start_go  = 1'b1;
            start_len = rem_r;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          rem_nxt = rem_dec;
          if (op_r == wsd_pkg::OP_PONG) begin
            if (rem_dec == 64'd0) phase_nxt = wsd_pkg::PH_HDR0;
          end else begin
            pidx_nxt = pidx_r + 2'd1;
            if (rem_dec == 64'd0) begin
              fe_go   = 1'b1;
              fe_has  = 1'b1;
              fe_data = data;
            end else if (wsd_pkg::is_data(op_r)) begin
              emit                = 1'b1;
              res.has_byte        = 1'b1;
              res.payload_byte    = data;
              res.byte_kind       = wsd_pkg::KIND_DATA;
              res.message_opcode  = mtype_r;
              res.event_res       = wsd_pkg::EV_NONE;
              res.payload_total   = sat_total(mtot_r - rem_dec);
            end else begin
              emit                = 1'b1;
              res.has_byte        = 1'b1;
              res.payload_byte    = data;
              res.byte_kind       = wsd_pkg::kind_of(op_r);
              res.message_opcode  = op_r;
              res.event_res       = wsd_pkg::EV_NONE;
              res.payload_total   = sat_total({57'd0, ctot_r - rem_dec[6:0]});
            end
          end
        end
        default: begin
        end
      endcase

      // Length complete: total check, then mask key, payload or frame end.
      if (len_go) begin
        rem_nxt = len_val;
        if (wsd_pkg::is_data(op_r)) begin
          if (len_val > room) err = wsd_pkg::ERR_TOO_LONG;
          else mtot_nxt = mtot_r + len_val;
        end else if (op_r != wsd_pkg::OP_PONG) begin
          if (len_val > {32'd0, max_len}) err = wsd_pkg::ERR_TOO_LONG;
          else ctot_nxt = len_val[6:0];
        end
        if (err == wsd_pkg::ERR_NONE) begin
          if (mask_en_nxt) begin
            key_nxt   = '0;
            hcnt_nxt  = wsd_pkg::KEY_BYTES;
            phase_nxt = wsd_pkg::PH_MASK;
          end else begin
            start_go  = 1'b1;
            start_len = len_val;
          end
        end
      end

      if (start_go) begin
        pidx_nxt = '0;
        if (start_len == 64'd0) fe_go = 1'b1;
        else phase_nxt = wsd_pkg::PH_PAYLOAD;
      end

      if (fe_go) begin
        phase_nxt = wsd_pkg::PH_HDR0;
        if (wsd_pkg::is_data(op_r)) begin
          if (fin_r || fe_has) begin
            emit               = 1'b1;
            res.has_byte       = fe_has;
            res.payload_byte   = fe_data;
            res.byte_kind      = wsd_pkg::KIND_DATA;
            res.message_opcode = mtype_r;
            res.event_res      = fin_r ? wsd_pkg::EV_MSG_DONE : wsd_pkg::EV_NONE;
            res.last_flag      = fin_r;
            res.payload_total  = sat_total(mtot_r);
          end
          if (fin_r) begin
            act_nxt   = 1'b0;
            mtype_nxt = '0;
            mtot_nxt  = '0;
          end
        end else if (op_r != wsd_pkg::OP_PONG) begin
          // A close frame drops any open data message.
          if (op_r == wsd_pkg::OP_CLOSE) begin
            act_nxt   = 1'b0;
            mtype_nxt = '0;
            mtot_nxt  = '0;
          end
          emit               = 1'b1;
          res.has_byte       = fe_has;
          res.payload_byte   = fe_data;
          res.byte_kind      = wsd_pkg::kind_of(op_r);
          res.message_opcode = op_r;
          res.event_res      = (op_r == wsd_pkg::OP_PING) ? wsd_pkg::EV_PING
                                                          : wsd_pkg::EV_CLOSE;
          res.last_flag      = 1'b1;
          res.payload_total  = sat_total({57'd0, ctot_nxt});
        end
      end

      // The first violation locks the parser until reset.
      if (err != wsd_pkg::ERR_NONE) begin
        phase_nxt          = wsd_pkg::PH_ERROR;
        emit               = 1'b1;
        res                = '0;
        res.byte_kind      = wsd_pkg::kind_of(op_nxt);
        res.message_opcode = op_nxt;
        res.event_res      = wsd_pkg::EV_ERROR;
        res.last_flag      = 1'b1;
        res.error_code     = err;
        res.payload_total  = wsd_pkg::is_ctrl(op_nxt) ? 32'd0 : sat_total(mtot_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wsd_pkg::PH_HDR0;
      fin_r     <= 1'b0;
      op_r      <= '0;
      act_r     <= 1'b0;
      mtype_r   <= '0;
      mask_en_r <= 1'b0;
      key_r     <= '0;
      hcnt_r    <= '0;
      rem_r     <= '0;
      pidx_r    <= '0;
      mtot_r    <= '0;
      ctot_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      fin_r     <= fin_nxt;
      op_r      <= op_nxt;
      act_r     <= act_nxt;
      mtype_r   <= mtype_nxt;
      mask_en_r <= mask_en_nxt;
      key_r     <= key_nxt;
      hcnt_r    <= hcnt_nxt;
      rem_r     <= rem_nxt;
      pidx_r    <= pidx_nxt;
      mtot_r    <= mtot_nxt;
      ctot_r    <= ctot_nxt;
    end
  end

  `WSD_ASSERT_NEXT(a_error_sticky, clk, rst_n, phase_r == wsd_pkg::PH_ERROR, phase_r == wsd_pkg::PH_ERROR, "error state left before reset")
  `WSD_ASSERT_IMPL(a_error_locks, clk, rst_n, emit && res.event_res == wsd_pkg::EV_ERROR, phase_nxt == wsd_pkg::PH_ERROR, "error reported without locking")
  `WSD_ASSERT_IMPL(a_err_code_match, clk, rst_n, emit, (res.event_res == wsd_pkg::EV_ERROR) == (res.error_code != wsd_pkg::ERR_NONE), "error code and event disagree")
  `WSD_ASSERT_IMPL(a_no_byte_zero, clk, rst_n, emit && !res.has_byte, res.payload_byte == 8'h00, "payload byte set without a byte")
  `WSD_ASSERT_IMPL(a_silent_idle, clk, rst_n, !step, !emit && phase_nxt == phase_r, "parser moved without a byte")

endmodule

`default_nettype wire

// ===== design/websocket_frame_deframer_core.sv =====
// A result request is registered and appears on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the input stalls only while a held result is stalled.
// Bytes that cause no result (headers, pong payload) pass with no output request.
// Reset (synchronous, active low) returns the parser to the first header byte,
// clears any sticky error and loads the register defaults.
// Depends on wsd_pkg and wsd_parser.
`default_nettype none

module websocket_frame_deframer_core #(
  parameter int TOTAL_COUNT_BITS = wsd_pkg::TOTAL_COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_has_byte,
  output logic [7:0]       out_payload_byte,
  output logic [1:0]       out_byte_kind,
  output logic [3:0]       out_message_opcode,
  output logic [2:0]       out_event_res,
  output logic             out_last_flag,
  output logic [2:0]       out_error_code,
  output logic [31:0]      out_payload_total,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0]   max_len_r, max_len_nxt;
  logic          closing_r, closing_nxt;
  logic          out_valid_r, out_valid_nxt;
  wsd_pkg::res_t res_r, res_nxt;
  wsd_pkg::res_t res;
  logic          emit;
  logic          step;
  logic          load;

  assign load     = !out_valid_r || !out_stall;
  assign in_stall = !load;
  assign step     = in_valid && load;

  wsd_parser #(
    .TOTAL_COUNT_BITS(TOTAL_COUNT_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_rx_byte),
    .max_len (max_len_r),
    .closing (closing_r),
    .emit    (emit),
    .res     (res)
  );

  always_comb begin
    max_len_nxt = max_len_r;
    closing_nxt = closing_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        wsd_pkg::CFG_IDX_MAX_LEN: max_len_nxt = cfg_wdata;
        wsd_pkg::CFG_IDX_CLOSING: closing_nxt = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // The result register refills whenever it is empty or being drained.
  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (load) begin
      out_valid_nxt = step && emit;
      res_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= wsd_pkg::MAX_LEN_RESET;
      closing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      max_len_r   <= max_len_nxt;
      closing_r   <= closing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_has_byte       = res_r.has_byte;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_byte_kind      = res_r.byte_kind;
  assign out_message_opcode = res_r.message_opcode;
  assign out_event_res      = res_r.event_res;
  assign out_last_flag      = res_r.last_flag;
  assign out_error_code     = res_r.error_code;
  assign out_payload_total  = res_r.payload_total;

endmodule

`default_nettype wire
